// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Needs a signal named clk and a signal named rst in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/piea_pkg.sv
// Shared types, codes and constants of the positional insert/erase array.
// No dependencies.
package piea_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int WORD_W    = 32;
  localparam int FUNC_W    = 3;
  localparam int POS_W     = 7;
  localparam int CNT_W     = 7;
  localparam int STAT_W    = 2;
  localparam int FAN_LG    = 3;
  localparam int FAN       = 1 << FAN_LG;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND = 3'd0,
    FN_DROP   = 3'd1,
    FN_INSERT = 3'd2,
    FN_ERASE  = 3'd3,
    FN_CLEAR  = 3'd4,
    FN_READ   = 3'd5,
    FN_WRITE  = 3'd6
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INS,
    OP_ERS,
    OP_WR,
    OP_RD
  } cell_op_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic     take;  // a transfer was accepted this cycle
    cell_op_t op;
  } cell_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_t;

  // Registered levels of the read-out OR tree, FAN children per node.
  function automatic int tree_levels(input int depth);
    int lv;
    int span;
    lv   = 1;
    span = FAN;
    while (span < depth) begin
      span = span * FAN;
      lv   = lv + 1;
    end
    return lv;
  endfunction

endpackage

// File: rtl/positional_insert_erase_array.sv
// Ordered array of up to DEPTH signed 32-bit words with a live count. Each
// transfer on the input carries one operation (append, drop last, insert,
// erase, clear, read, write) and yields exactly one result with the read word,
// the new count and a status. Entries live in a row of cells that shift all at
// once, so insert and erase finish in the cycle of acceptance. The read word is
// gathered by a registered 8-way OR tree of ceil(log8(DEPTH)) levels, and the
// block takes the next item once the result has reached the output register,
// which may hold it under stall while the next item is already taken. No
// clearing pass follows reset; the stored words keep their contents and only
// the count and the control state are cleared.
// Depends on piea_pkg, piea_cell and piea_or_tree.
module positional_insert_erase_array
  import piea_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [FUNC_W-1:0]        func,
  input  logic [POS_W-1:0]         position,
  input  logic signed [WORD_W-1:0] data_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] read_data,
  output logic [CNT_W-1:0]         item_count,
  output logic [STAT_W-1:0]        status
);

  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int PW     = (CW > POS_W) ? CW : POS_W;
  localparam int LEVELS = tree_levels(DEPTH);
  localparam int LW     = $clog2(LEVELS + 1);

  state_t            state, state_next;
  logic [CW-1:0]     live_count, live_count_next;
  logic [LW-1:0]     wait_cnt, wait_cnt_next;
  status_t           pend_status, pend_status_next;
  logic              accept;
  logic              load_out;
  logic              full;
  logic [PW-1:0]     cnt_ext;
  logic [PW-1:0]     pos_ext;
  logic [AW-1:0]     tgt;
  cell_op_t          op;
  cell_cmd_t         cmd;
  logic [WORD_W-1:0] words    [DEPTH];
  logic [WORD_W-1:0] rd_words [DEPTH];
  logic [WORD_W-1:0] tree_root;

  assign accept  = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign full    = (live_count == CW'(DEPTH));
  assign cnt_ext = PW'(live_count);
  assign pos_ext = PW'(position);

  // Decode of the accepted operation against the current count.
  always_comb begin
    op               = OP_NONE;
    tgt              = AW'(position);
    live_count_next  = live_count;
    pend_status_next = pend_status;
    if (accept) begin
      pend_status_next = ST_DONE;
      unique case (func_t'(func))
        FN_APPEND: begin
          tgt = AW'(live_count);
          if (full) begin
            pend_status_next = ST_FULL;
          end else begin
            op              = OP_WR;
            live_count_next = CW'(live_count + 1'b1);
          end
        end
        FN_DROP: begin
          if (live_count == '0) begin
            pend_status_next = ST_BAD;
          end else begin
            live_count_next = CW'(live_count - 1'b1);
          end
        end
        FN_INSERT: begin
          if (pos_ext > cnt_ext) begin
            pend_status_next = ST_BAD;
          end else if (full) begin
            pend_status_next = ST_FULL;
          end else begin
            op              = OP_INS;
            live_count_next = CW'(live_count + 1'b1);
          end
        end
        FN_ERASE: begin
          if (pos_ext >= cnt_ext) begin
            pend_status_next = ST_BAD;
          end else begin
            op              = OP_ERS;
            live_count_next = CW'(live_count - 1'b1);
          end
        end
        FN_CLEAR: begin
          live_count_next = '0;
        end
        FN_READ: begin
          if (pos_ext >= cnt_ext) begin
            pend_status_next = ST_BAD;
          end else begin
            op = OP_RD;
          end
        end
        FN_WRITE: begin
          if (pos_ext >= cnt_ext) begin
            pend_status_next = ST_BAD;
          end else begin
            op = OP_WR;
          end
        end
        default: begin
          pend_status_next = ST_BAD;
        end
      endcase
    end
  end

  assign cmd.take = accept;
  assign cmd.op   = op;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left_w;
    logic [WORD_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = words[i];
    end else begin : g_left
      assign left_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = words[i];
    end else begin : g_right
      assign right_w = words[i+1];
    end
    piea_cell #(
      .DEPTH (DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .tgt     (tgt),
      .data_in (data_in),
      .left    (left_w),
      .right   (right_w),
      .word    (words[i]),
      .rd_word (rd_words[i])
    );
  end

  piea_or_tree #(
    .DEPTH (DEPTH)
  ) u_tree (
    .clk  (clk),
    .leaf (rd_words),
    .root (tree_root)
  );

  // Sequencer: wait for the tree, then hand the result to the output register.
  always_comb begin
    state_next    = state;
    wait_cnt_next = wait_cnt;
    load_out      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next    = S_BUSY;
          wait_cnt_next = LW'(LEVELS);
        end
      end
      S_BUSY: begin
        if (wait_cnt != '0) begin
          wait_cnt_next = LW'(wait_cnt - 1'b1);
        end else if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      wait_cnt   <= '0;
      live_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      wait_cnt   <= wait_cnt_next;
      live_count <= live_count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_status <= pend_status_next;
    if (load_out) begin
      read_data  <= tree_root;
      item_count <= CNT_W'(live_count);
      status     <= pend_status;
    end
  end

endmodule

// File: rtl/piea_cell.sv
// One entry of the array: holds a word, shifts with its neighbours.
// Depends on piea_pkg.
module piea_cell
  import piea_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cell_cmd_t                cmd,
  input  logic [$clog2(DEPTH)-1:0] tgt,
  input  logic [WORD_W-1:0]        data_in,
  input  logic [WORD_W-1:0]        left,
  input  logic [WORD_W-1:0]        right,
  output logic [WORD_W-1:0]        word,
  output logic [WORD_W-1:0]        rd_word
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] IDX = AW'(INDEX);

  logic rd_sel;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_INS: begin
        if (IDX > tgt) begin
          word <= left;
        end else if (IDX == tgt) begin
          word <= data_in;
        end
      end
      OP_ERS: begin
        if (IDX >= tgt) begin
          word <= right;
        end
      end
      OP_WR: begin
        if (IDX == tgt) begin
          word <= data_in;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_sel <= 1'b0;
    end else if (cmd.take) begin
      rd_sel <= (cmd.op == OP_RD) && (IDX == tgt);
    end
  end

  assign rd_word = rd_sel ? word : '0;

endmodule

// File: rtl/piea_or_tree.sv
// Registered OR tree that gathers the one selected word from the cell row.
// Depends on piea_pkg.
module piea_or_tree
  import piea_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic [WORD_W-1:0] leaf [DEPTH],
  output logic [WORD_W-1:0] root
);

  localparam int LEVELS = tree_levels(DEPTH);
  localparam int PAD    = 1 << (FAN_LG * LEVELS);

  logic [WORD_W-1:0] node [LEVELS+1][PAD];

  for (genvar i = 0; i < PAD; i++) begin : g_leaf
    if (i < DEPTH) begin : g_live
      assign node[0][i] = leaf[i];
    end else begin : g_pad
      assign node[0][i] = '0;
    end
  end

  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    for (genvar k = 0; k < PAD; k++) begin : g_node
      if (k < (PAD >> (FAN_LG * l))) begin : g_or
        logic [WORD_W-1:0] acc;
        always_comb begin
          acc = '0;
          for (int j = 0; j < FAN; j++) begin
            acc = acc | node[l-1][k*FAN + j];
          end
        end
        always_ff @(posedge clk) begin
          node[l][k] <= acc;
        end
      end else begin : g_unused
        assign node[l][k] = '0;
      end
    end
  end

  assign root = node[LEVELS][0];

endmodule

// File: rtl/piea_checker.sv
// Port-level checks on the positional insert/erase array, bound to its top.
// Depends on piea_pkg and assert_macros.svh.
`include "assert_macros.svh"

module piea_checker
  import piea_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [WORD_W-1:0] read_data,
  input logic [CNT_W-1:0]         item_count,
  input logic [STAT_W-1:0]        status
);

  // A stalled result must not vanish.
  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped under stall")

  // An operation that did not complete carries no word.
  `ASSERT_CLK(a_rd_zero, out_valid && (status != ST_DONE) |-> read_data == '0, "stray word")

  `ASSERT_CLK(a_status_code, out_valid |-> status <= ST_BAD, "bad status code")

  // The count never passes the capacity (checked where it fits the field).
  `ASSERT_CLK(a_count_cap, out_valid && DEPTH < 128 |-> int'(item_count) <= DEPTH, "over capacity")

endmodule

bind positional_insert_erase_array piea_checker #(
  .DEPTH (DEPTH)
) u_piea_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .read_data  (read_data),
  .item_count (item_count),
  .status     (status)
);
